[design/pnct_pkg.sv]
// Package: shared constants, types and state encoding for the nearest palette colour table.
`timescale 1ns / 1ps
`default_nettype none
package pnct_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int COL_W  = 32;
    localparam int KIND_W = 2;

    localparam logic [COL_W-1:0] START_DIST   = 32'h00ff_ffff;
    localparam logic [COL_W-1:0] OPAQUE_RESET = 32'hff00_0000;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_MATCH  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic             closer;
        logic [COL_W-1:0] delta;
    } t_cmp;

endpackage
`default_nettype wire

[design/pnct_if.sv]
// Interfaces: operation input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface pnct_in_if;
    logic                       valid;
    logic                       ready;
    logic [pnct_pkg::KIND_W-1:0] kind;
    logic [pnct_pkg::COL_W-1:0]  color;
    logic [pnct_pkg::ADDR_W-1:0] index;

    modport source (output valid, kind, color, index, input ready);
    modport sink   (input valid, kind, color, index, output ready);
endinterface

interface pnct_out_if;
    logic                       valid;
    logic                       ready;
    logic [pnct_pkg::COL_W-1:0]  match_color;
    logic                       error;
    logic [pnct_pkg::CNT_W-1:0]  entry_count;

    modport source (output valid, match_color, error, entry_count, input ready);
    modport sink   (input valid, match_color, error, entry_count, output ready);
endinterface
`default_nettype wire

[design/pnct_dist.sv]
// Shared distance unit: absolute difference of entry and base, compared with best distance.
`timescale 1ns / 1ps
`default_nettype none
module pnct_dist (
    input  wire logic [pnct_pkg::COL_W-1:0] i_entry,
    input  wire logic [pnct_pkg::COL_W-1:0] i_base,
    input  wire logic [pnct_pkg::COL_W-1:0] i_best_dist,
    output pnct_pkg::t_cmp                  o_cmp
);
    import pnct_pkg::*;

    logic [COL_W-1:0] diff;

    always_comb begin
        if (i_entry > i_base) begin
            diff = i_entry - i_base;
        end else begin
            diff = i_base - i_entry;
        end
        o_cmp.delta  = diff;
        o_cmp.closer = (diff < i_best_dist);
    end

endmodule
`default_nettype wire

[design/palette_nearest_color_table.sv]
// Top level: nearest palette colour table with sequencer, palette memory and shared distance unit.
`timescale 1ns / 1ps
`default_nettype none
// Holds an ordered palette of up to 16 colours and takes one operation per input beat:
// append, remove at index, or closest match. One item is in flight at a time; ready is
// low from acceptance until the result beat is taken. A match does one palette read per
// cycle through the single registered memory read port into one distance unit, and a
// remove does a read and a write per moved entry on the same port pair. Error cases and
// the unused kind go straight to the result. No clearing pass after reset: entries at or
// above the count are never used.
module palette_nearest_color_table (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    pnct_in_if.sink                       i_in,
    pnct_out_if.source                    o_out,
    input  wire logic                     i_cfg_we,
    input  wire logic [pnct_pkg::COL_W-1:0] i_cfg_wdata
);
    import pnct_pkg::*;

    t_state            r_state, n_state;
    logic [COL_W-1:0]  r_mask;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic              r_pend, n_pend;
    logic [COL_W-1:0]  r_base, n_base;
    logic [COL_W-1:0]  r_best, n_best;
    logic [COL_W-1:0]  r_dist, n_dist;
    logic [COL_W-1:0]  r_res_match, n_res_match;
    logic              r_res_err, n_res_err;
    logic [COL_W-1:0]  r_rd_data;
    logic [COL_W-1:0]  r_mem [DEPTH];

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [COL_W-1:0]  mem_wd;
    logic [ADDR_W-1:0] mem_ra;
    logic [CNT_W-1:0]  ptr_nx;
    logic              in_acc;
    logic              out_acc;
    t_kind             kind;
    t_cmp              cmp;

    assign in_acc  = i_in.valid & i_in.ready;
    assign out_acc = o_out.valid & o_out.ready;
    assign kind    = t_kind'(i_in.kind);
    assign ptr_nx  = r_ptr + CNT_W'(1);

    pnct_dist u_dist (
        .i_entry     (r_rd_data),
        .i_base      (r_base),
        .i_best_dist (r_dist),
        .o_cmp       (cmp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (kind == KIND_MATCH) begin
                        n_state = ST_MATCH;
                    end else if (kind == KIND_REMOVE && {1'b0, i_in.index} < r_count) begin
                        n_state = ST_SHIFT_RD;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_MATCH: begin
                if (r_ptr >= r_count && !r_pend) begin
                    n_state = ST_RESULT;
                end
            end
            ST_SHIFT_RD: begin
                if (ptr_nx < r_count) begin
                    n_state = ST_SHIFT_WR;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_SHIFT_WR: begin
                n_state = ST_SHIFT_RD;
            end
            ST_RESULT: begin
                if (out_acc) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_base      = r_base;
        n_best      = r_best;
        n_dist      = r_dist;
        n_res_match = r_res_match;
        n_res_err   = r_res_err;
        mem_we      = 1'b0;
        mem_wa      = r_count[ADDR_W-1:0];
        mem_wd      = i_in.color;
        mem_ra      = r_ptr[ADDR_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res_match = '0;
                    n_res_err   = 1'b0;
                    unique case (kind)
                        KIND_APPEND: begin
                            if (r_count >= CNT_W'(DEPTH)) begin
                                n_res_err = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        KIND_REMOVE: begin
                            if ({1'b0, i_in.index} >= r_count) begin
                                n_res_err = 1'b1;
                            end else begin
                                n_ptr = {1'b0, i_in.index};
                            end
                        end
                        KIND_MATCH: begin
                            n_base = i_in.color & ~r_mask;
                            n_best = i_in.color & ~r_mask;
                            n_dist = START_DIST;
                            n_ptr  = '0;
                            n_pend = 1'b0;
                        end
                        KIND_NONE: begin
                        end
                    endcase
                end
            end
            ST_MATCH: begin
                if (r_pend && cmp.closer) begin
                    n_best = r_rd_data;
                    n_dist = cmp.delta;
                end
                if (r_ptr < r_count) begin
                    n_ptr  = ptr_nx;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_res_match = r_best | r_mask;
                    end
                end
            end
            ST_SHIFT_RD: begin
                mem_ra = ptr_nx[ADDR_W-1:0];
                if (ptr_nx >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ST_SHIFT_WR: begin
                mem_we = 1'b1;
                mem_wa = r_ptr[ADDR_W-1:0];
                mem_wd = r_rd_data;
                n_ptr  = ptr_nx;
            end
            ST_RESULT: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mask  <= OPAQUE_RESET;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_base      <= n_base;
        r_best      <= n_best;
        r_dist      <= n_dist;
        r_res_match <= n_res_match;
        r_res_err   <= n_res_err;
    end

    // palette memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = (r_state == ST_RESULT);
    assign o_out.match_color = r_res_match;
    assign o_out.error       = r_res_err;
    assign o_out.entry_count = r_count;

endmodule
`default_nettype wire

[design/pnct_chk.sv]
// Checker: port-level assertions on the nearest palette colour table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pnct_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [pnct_pkg::COL_W-1:0] i_out_match_color,
    input wire logic                       i_out_error,
    input wire logic [pnct_pkg::CNT_W-1:0] i_out_entry_count
);
    import pnct_pkg::*;

    // one item in flight: never ready while a result beat is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready after accepted beat");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> !i_out_valid)
        else $error("result repeated");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_entry_count <= CNT_W'(DEPTH)))
        else $error("entry count beyond depth");

    a_error_no_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_error) |-> (i_out_match_color == '0))
        else $error("colour reported with error");

endmodule

bind palette_nearest_color_table pnct_chk u_pnct_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_match_color (o_out.match_color),
    .i_out_error       (o_out.error),
    .i_out_entry_count (o_out.entry_count)
);
`default_nettype wire

[test/tb.sv]
// Testbench for palette_nearest_color_table: directed table then random ops, checked by a predictor.
`timescale 1ns / 1ps
module tb;
    import pnct_pkg::*;

    typedef struct packed {
        t_kind             kind;
        logic [COL_W-1:0]  color;
        logic [ADDR_W-1:0] index;
    } pal_op_t;

    typedef struct packed {
        logic [COL_W-1:0] match_color;
        logic             error;
        logic [CNT_W-1:0] entry_count;
    } pal_result_t;

    typedef struct packed {
        pal_op_t     op;
        logic        typed;
        pal_result_t res;
    } dir_row_t;

    localparam int N_DIRECTED = 26;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 125;
    localparam int N_PHASES = 6;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{'{KIND_MATCH,  32'h1234_5678, 4'd0},  1'b1, '{32'hff34_5678, 1'b0, 5'd0}},
        '{'{KIND_REMOVE, 32'h0000_0000, 4'd0},  1'b1, '{32'h0000_0000, 1'b1, 5'd0}},
        '{'{KIND_NONE,   32'hffff_ffff, 4'd15}, 1'b1, '{32'h0000_0000, 1'b0, 5'd0}},
        '{'{KIND_APPEND, 32'h0000_0000, 4'd0},  1'b1, '{32'h0000_0000, 1'b0, 5'd1}},
        '{'{KIND_APPEND, 32'hffff_ffff, 4'd0},  1'b1, '{32'h0000_0000, 1'b0, 5'd2}},
        '{'{KIND_MATCH,  32'h0000_0000, 4'd0},  1'b1, '{32'hff00_0000, 1'b0, 5'd2}},
        '{'{KIND_MATCH,  32'hffff_ffff, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h0012_3456, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h8000_0000, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h00ff_00ff, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h7fff_ffff, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h0100_0000, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h00ff_fffe, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h0012_3456, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h0080_0000, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h0000_0001, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h5555_5555, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'haaaa_aaaa, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h0012_3400, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h0040_4040, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'hff80_8080, 4'd0},  1'b0, '0},
        '{'{KIND_APPEND, 32'h0000_ffff, 4'd0},  1'b1, '{32'h0000_0000, 1'b1, 5'd16}},
        '{'{KIND_REMOVE, 32'h0000_0000, 4'd15}, 1'b0, '0},
        '{'{KIND_REMOVE, 32'h0000_0000, 4'd0},  1'b0, '0},
        '{'{KIND_REMOVE, 32'h0000_0000, 4'd15}, 1'b1, '{32'h0000_0000, 1'b1, 5'd14}},
        '{'{KIND_MATCH,  32'hff12_3401, 4'd0},  1'b0, '0}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [COL_W-1:0] i_cfg_wdata;

    pnct_in_if  in_ch ();
    pnct_out_if out_ch ();

    palette_nearest_color_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [COL_W-1:0] mask_shadow;
    logic [COL_W-1:0] pal_entries [DEPTH];
    int               pal_count;
    pal_result_t      pending_results [$];
    int               fail_count;
    int               hold_left;
    int               stall_left;
    bit               no_idle;
    bit               arm_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic pal_result_t apply_to_palette(input pal_op_t op);
        pal_result_t      r;
        logic [COL_W-1:0] base;
        logic [COL_W-1:0] diff;
        logic [COL_W-1:0] best_dist;
        int               i;
        r = '0;
        case (op.kind)
            KIND_APPEND: begin
                if (pal_count >= DEPTH) begin
                    r.error = 1'b1;
                end else begin
                    pal_entries[pal_count] = op.color;
                    pal_count++;
                end
            end
            KIND_REMOVE: begin
                if (int'(op.index) >= pal_count) begin
                    r.error = 1'b1;
                end else begin
                    for (i = int'(op.index); i + 1 < pal_count; i++) begin
                        pal_entries[i] = pal_entries[i+1];
                    end
                    pal_count--;
                end
            end
            KIND_MATCH: begin
                base = op.color & ~mask_shadow;
                r.match_color = base;
                best_dist = START_DIST;
                for (i = 0; i < pal_count; i++) begin
                    diff = (pal_entries[i] > base) ? pal_entries[i] - base : base - pal_entries[i];
                    if (diff < best_dist) begin
                        best_dist = diff;
                        r.match_color = pal_entries[i];
                    end
                end
                r.match_color = r.match_color | mask_shadow;
            end
            default: ;
        endcase
        r.entry_count = CNT_W'(pal_count);
        return r;
    endfunction

    // near or at an existing entry four times in ten, so the distance search has real contenders
    function automatic logic [COL_W-1:0] draw_color();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3 || pal_count == 0) begin
            return $urandom;
        end else if (pick < 6) begin
            return $urandom & ~mask_shadow;
        end else if (pick < 9) begin
            return pal_entries[$urandom_range(0, pal_count - 1)]
                + COL_W'($urandom_range(0, 512) - 256);
        end
        return pal_entries[$urandom_range(0, pal_count - 1)];
    endfunction

    function automatic pal_op_t draw_palette_op();
        pal_op_t op;
        int      roll;
        int      lim_app;
        int      lim_rem;
        int      lim_mat;
        roll = $urandom_range(0, 99);
        if (pal_count < 6) begin
            lim_app = 50; lim_rem = 65; lim_mat = 97;
        end else if (pal_count >= DEPTH) begin
            lim_app = 15; lim_rem = 50; lim_mat = 97;
        end else begin
            lim_app = 30; lim_rem = 55; lim_mat = 96;
        end
        op.color = $urandom;
        op.index = ADDR_W'($urandom_range(0, DEPTH - 1));
        if (roll < lim_app) begin
            op.kind  = KIND_APPEND;
            op.color = draw_color();
        end else if (roll < lim_rem) begin
            op.kind = KIND_REMOVE;
            if (pal_count > 0 && $urandom_range(0, 99) < 85) begin
                op.index = ADDR_W'($urandom_range(0, pal_count - 1));
            end
        end else if (roll < lim_mat) begin
            op.kind  = KIND_MATCH;
            op.color = draw_color();
        end else begin
            op.kind = KIND_NONE;
        end
        return op;
    endfunction

    task automatic send_op(input pal_op_t op, input bit typed, input pal_result_t typed_res);
        int          gap;
        pal_result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= op.kind;
        in_ch.color <= op.color;
        in_ch.index <= op.index;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        predicted = apply_to_palette(op);
        pending_results.push_back(typed ? typed_res : predicted);
        if (arm_hold) begin
            hold_left = HOLD_CYCLES;
            arm_hold  = 1'b0;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_opaque_mask(input logic [COL_W-1:0] value);
        drain_results();
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mask_shadow = value;
    endtask

    // receiver: long hold-off first, then the per-beat stall
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        pal_result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected beat match_color %h error %b entry_count %0d",
                    $time, out_ch.match_color, out_ch.error, out_ch.entry_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.match_color !== want.match_color) begin
                    $display("%0t: match_color expected %h actual %h",
                        $time, want.match_color, out_ch.match_color);
                    fail_count++;
                end
                if (out_ch.error !== want.error) begin
                    $display("%0t: error expected %b actual %b", $time, want.error, out_ch.error);
                    fail_count++;
                end
                if (out_ch.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                        $time, want.entry_count, out_ch.entry_count);
                    fail_count++;
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 4);
        end
    end

    initial begin : stimulus
        logic [COL_W-1:0] phase_mask [N_PHASES];
        int               row;
        int               phase;
        int               n;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.kind  = KIND_NONE;
        in_ch.color = '0;
        in_ch.index = '0;
        mask_shadow = OPAQUE_RESET;
        pal_count   = 0;
        fail_count  = 0;
        hold_left   = 0;
        stall_left  = 0;
        no_idle     = 1'b0;
        arm_hold    = 1'b0;
        for (n = 0; n < DEPTH; n++) pal_entries[n] = '0;
        phase_mask[0] = 32'h0000_0000;
        phase_mask[1] = 32'hffff_ffff;
        phase_mask[2] = 32'hff00_0000;
        phase_mask[3] = $urandom;
        phase_mask[4] = 32'h0000_00ff;
        phase_mask[5] = $urandom;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (row = 0; row < N_DIRECTED; row++) begin
            send_op(DIRECTED[row].op, DIRECTED[row].typed, DIRECTED[row].res);
        end
        in_ch.valid <= 1'b0;

        for (phase = 0; phase < N_PHASES; phase++) begin
            write_opaque_mask(phase_mask[phase]);
            no_idle  = (phase == 3);
            arm_hold = (phase == 1);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_op(draw_palette_op(), 1'b0, '0);
            end
            in_ch.valid <= 1'b0;
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

[files.f]
design/pnct_pkg.sv
design/pnct_if.sv
design/pnct_dist.sv
design/palette_nearest_color_table.sv
design/pnct_chk.sv
test/tb.sv
